### src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, muted while arst_n is low.
`define SRRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Plain condition checked on every rising clk edge, muted while arst_n is low.
`define SRRD_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

### src/srrd_pkg.sv
`default_nettype none
package srrd_pkg;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RAW_MODE     = 2'd2;

	localparam logic [7:0] CMD_SKIP_BIT   = 8'h80;
	localparam logic [7:0] CMD_REPEAT_BIT = 8'h40;
	localparam logic [7:0] CMD_COUNT_MASK = 8'h3f;
	localparam logic [7:0] CMD_SKIP_MASK  = 8'h7f;

	typedef enum logic [1:0] {
		PH_CMD     = 2'd0,
		PH_REPEAT  = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	// controller -> datapath
	typedef struct packed {
		logic take;   // input transaction this cycle
		logic step;   // emit next pixel of a repeat run
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_busy;  // result register full and stalled
		logic run_more;  // accepted byte starts a run of more than one pixel
		logic run_end;   // current step emits the final pixel of the run
	} status_t;

endpackage
`default_nettype wire

### src/srrd_ctrl.sv
`default_nettype none
module srrd_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 cfg_ready,
	input  srrd_pkg::status_t    status,
	output srrd_pkg::cmd_t       cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q == ST_RUN) || status.out_busy;
	assign cmd.take  = in_valid && !in_stall;
	assign cmd.step  = (state_q == ST_RUN) && !status.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take && status.run_more)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cmd.step && status.run_end)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/srrd_datapath.sv
`default_nettype none
module srrd_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_valid,
	input  wire                  cfg_ready,
	input  wire  [1:0]           cfg_index,
	input  wire  [7:0]           cfg_data,
	input  wire  [7:0]           data_byte,
	input  wire                  frame_start,
	input  srrd_pkg::cmd_t       cmd,
	input  wire                  out_stall,
	output srrd_pkg::status_t    status,
	output logic                 out_valid,
	output logic [8:0]           pixel_x,
	output logic [7:0]           pixel_y,
	output logic [7:0]           color_index,
	output logic                 last_of_run
);

	logic [7:0] width_q;
	logic [7:0] height_q;
	logic       raw_q;

	srrd_pkg::phase_t phase_q;
	logic [5:0] pend_q;
	logic [8:0] col_q;
	logic [8:0] row_q;
	logic       out_valid_q;

	srrd_pkg::phase_t phase_b, phase_n;
	logic [5:0] pend_b, pend_n;
	logic [8:0] col_b, col_n, col_f;
	logic [8:0] row_b, row_f;
	logic       active, emit, last_n, chk, more, endr;

	always_comb begin
		// frame_start clears position and phase before the byte is handled
		if (cmd.take && frame_start) begin
			phase_b = srrd_pkg::PH_CMD;
			pend_b  = 6'd0;
			col_b   = 9'd0;
			row_b   = 9'd0;
		end else begin
			phase_b = phase_q;
			pend_b  = pend_q;
			col_b   = col_q;
			row_b   = row_q;
		end
		active  = (width_q != 8'd0) && (row_b < {1'b0, height_q});
		phase_n = phase_b;
		pend_n  = pend_b;
		col_n   = col_b;
		emit    = 1'b0;
		last_n  = 1'b1;
		chk     = 1'b0;
		more    = 1'b0;
		endr    = 1'b0;

		if (cmd.step) begin
			emit   = 1'b1;
			chk    = 1'b1;
			last_n = (pend_q == 6'd1);
			col_n  = col_q + 9'd1;
			pend_n = pend_q - 6'd1;
			if (pend_q == 6'd1) begin
				phase_n = srrd_pkg::PH_CMD;
				endr    = 1'b1;
			end
		end else if (cmd.take && active) begin
			chk = 1'b1;
			if (raw_q) begin
				emit    = 1'b1;
				col_n   = col_b + 9'd1;
				phase_n = srrd_pkg::PH_CMD;
				pend_n  = 6'd0;
			end else begin
				unique case (phase_b)
					srrd_pkg::PH_REPEAT: begin
						if (pend_b == 6'd0) begin
							phase_n = srrd_pkg::PH_CMD;
						end else begin
							emit   = 1'b1;
							last_n = (pend_b == 6'd1);
							col_n  = col_b + 9'd1;
							pend_n = pend_b - 6'd1;
							if (pend_b == 6'd1)
								phase_n = srrd_pkg::PH_CMD;
							else
								more = 1'b1;
						end
					end
					srrd_pkg::PH_LITERAL: begin
						emit   = 1'b1;
						col_n  = col_b + 9'd1;
						pend_n = pend_b - 6'd1;
						if (pend_b == 6'd1)
							phase_n = srrd_pkg::PH_CMD;
					end
					srrd_pkg::PH_CMD: begin
						if ((data_byte & srrd_pkg::CMD_SKIP_BIT) != 8'd0) begin
							col_n = col_b + {1'b0, data_byte & srrd_pkg::CMD_SKIP_MASK};
						end else if ((data_byte & srrd_pkg::CMD_REPEAT_BIT) != 8'd0) begin
							pend_n  = 6'(data_byte & srrd_pkg::CMD_COUNT_MASK);
							phase_n = srrd_pkg::PH_REPEAT;
						end else begin
							pend_n = 6'(data_byte & srrd_pkg::CMD_COUNT_MASK);
							if (pend_n != 6'd0)
								phase_n = srrd_pkg::PH_LITERAL;
						end
					end
					default: phase_n = srrd_pkg::PH_CMD;
				endcase
			end
		end

		// row ends at a command boundary once the column reaches the width
		if (chk && phase_n == srrd_pkg::PH_CMD && col_n >= {1'b0, width_q}) begin
			col_f = 9'd0;
			row_f = row_b + 9'd1;
		end else begin
			col_f = col_n;
			row_f = row_b;
		end
	end

	assign status.out_busy = out_valid_q && out_stall;
	assign status.run_more = more;
	assign status.run_end  = endr;
	assign out_valid       = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 8'd0;
			height_q    <= 8'd0;
			raw_q       <= 1'b0;
			phase_q     <= srrd_pkg::PH_CMD;
			pend_q      <= 6'd0;
			col_q       <= 9'd0;
			row_q       <= 9'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					srrd_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
					srrd_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
					srrd_pkg::REG_RAW_MODE:     raw_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.take || cmd.step) begin
				phase_q <= phase_n;
				pend_q  <= pend_n;
				col_q   <= col_f;
				row_q   <= row_f;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x     <= col_b;
			pixel_y     <= row_b[7:0];
			last_of_run <= last_n;
			if (cmd.take)
				color_index <= data_byte;
		end
	end

endmodule
`default_nettype wire

### src/sprite_row_rle_decoder.sv
// A pixel enters the result register in the cycle after its byte is accepted.
// Throughput: one byte per cycle for skip, literal, raw and count bytes while the result side
// does not stall; a repeat color byte emits its first pixel on acceptance, then stalls the
// input while the rest of the run emits one pixel per cycle unless the result side stalls.
// Output stall backs up into the input through the single result register.
// Reset (arst_n low): column, row, decode phase, count and registers clear; no result valid.
`default_nettype none
module sprite_row_rle_decoder (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [1:0] cfg_index,
	input  wire  [7:0] cfg_data,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] data_byte,
	input  wire        frame_start,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [8:0] pixel_x,
	output logic [7:0] pixel_y,
	output logic [7:0] color_index,
	output logic       last_of_run
);

	srrd_pkg::cmd_t    cmd;
	srrd_pkg::status_t status;

	srrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	srrd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.cmd         (cmd),
		.out_stall   (out_stall),
		.status      (status),
		.out_valid   (out_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.color_index (color_index),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

### src/srrd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module srrd_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_stall,
	input wire       out_valid,
	input wire       out_stall,
	input wire [8:0] pixel_x,
	input wire [7:0] pixel_y,
	input wire [7:0] color_index,
	input wire       last_of_run
);

	`SRRD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
	`SRRD_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(pixel_x) && $stable(pixel_y) && $stable(color_index) && $stable(last_of_run), "stalled result changed")
	`SRRD_CHECK(a_backpressure, !(out_valid && out_stall) || in_stall, "input taken while result stalled")
	`SRRD_CHECK(a_run_blocks_input, !(out_valid && !last_of_run) || in_stall, "input taken mid-run")
	`SRRD_ASSERT(a_run_continues, out_valid && !out_stall && !last_of_run |=> out_valid, "repeat run broke off")

endmodule

bind sprite_row_rle_decoder srrd_checker u_srrd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.color_index (color_index),
	.last_of_run (last_of_run)
);
`default_nettype wire

### test/sprite_row_rle_decoder_tb.sv
`timescale 1ns / 100ps
module sprite_row_rle_decoder_tb;

	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [7:0] data;
		logic       start;
		bit         drain;  // hold this byte back until all pixels are out
	} byte_item_t;

	typedef struct {
		logic [8:0] x;
		logic [7:0] y;
		logic [7:0] color;
		logic       last;
	} pixel_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = '0;
	logic       frame_start = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [8:0] pixel_x;
	logic [7:0] pixel_y;
	logic [7:0] color_index;
	logic       last_of_run;

	sprite_row_rle_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.color_index(color_index),
		.last_of_run(last_of_run)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	byte_item_t byte_q[$];
	pixel_t     pending_pixels[$];

	int cycle_cnt = 0;
	int errors = 0;
	int bytes_sent = 0;
	int pixels_checked = 0;
	int settings_cnt = 0;

	// predictor copy of registers and decode state
	logic [7:0]       frame_w = '0;
	logic [7:0]       frame_h = '0;
	logic             raw_on = 1'b0;
	srrd_pkg::phase_t dec_phase = srrd_pkg::PH_CMD;
	logic [5:0]       run_cnt = '0;
	logic [8:0]       col_pos = '0;
	logic [8:0]       row_pos = '0;

	task automatic report_mismatch(input string msg);
		if (errors < 100)
			$display("ERROR cycle %0d: %s", cycle_cnt, msg);
		errors++;
	endtask

	function automatic void add_pixel(input logic [8:0] x, input logic [7:0] color,
			input logic last);
		pixel_t p;
		p.x = x;
		p.y = row_pos[7:0];
		p.color = color;
		p.last = last;
		pending_pixels = {pending_pixels, p};
	endfunction

	function automatic void close_row_if_full();
		if (dec_phase == srrd_pkg::PH_CMD && col_pos >= {1'b0, frame_w}) begin
			col_pos = '0;
			row_pos = row_pos + 9'd1;
		end
	endfunction

	function automatic void predict_pixels(input logic [7:0] b, input logic start);
		if (start) begin
			dec_phase = srrd_pkg::PH_CMD;
			run_cnt = '0;
			col_pos = '0;
			row_pos = '0;
		end
		if (frame_w == 8'd0 || row_pos >= {1'b0, frame_h})
			return;
		if (raw_on) begin
			dec_phase = srrd_pkg::PH_CMD;
			run_cnt = '0;
			add_pixel(col_pos, b, 1'b1);
			col_pos = col_pos + 9'd1;
			close_row_if_full();
		end else if (dec_phase == srrd_pkg::PH_REPEAT) begin
			for (int i = 0; i < run_cnt; i++)
				add_pixel(col_pos + 9'(i), b, i + 1 == run_cnt);
			col_pos = col_pos + 9'(run_cnt);
			run_cnt = '0;
			dec_phase = srrd_pkg::PH_CMD;
			close_row_if_full();
		end else if (dec_phase == srrd_pkg::PH_LITERAL) begin
			add_pixel(col_pos, b, 1'b1);
			col_pos = col_pos + 9'd1;
			run_cnt = run_cnt - 6'd1;
			if (run_cnt == 6'd0) begin
				dec_phase = srrd_pkg::PH_CMD;
				close_row_if_full();
			end
		end else if ((b & srrd_pkg::CMD_SKIP_BIT) != 0) begin
			col_pos = col_pos + 9'(b & srrd_pkg::CMD_SKIP_MASK);
			close_row_if_full();
		end else if ((b & srrd_pkg::CMD_REPEAT_BIT) != 0) begin
			run_cnt = 6'(b & srrd_pkg::CMD_COUNT_MASK);
			dec_phase = srrd_pkg::PH_REPEAT;
		end else begin
			run_cnt = 6'(b & srrd_pkg::CMD_COUNT_MASK);
			if (run_cnt != 6'd0)
				dec_phase = srrd_pkg::PH_LITERAL;
			else
				close_row_if_full();
		end
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic start);
		byte_item_t it;
		it.data = b;
		it.start = start;
		it.drain = ($urandom_range(0, 49) == 0);
		byte_q = {byte_q, it};
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			srrd_pkg::REG_FRAME_WIDTH: frame_w = val;
			srrd_pkg::REG_FRAME_HEIGHT: frame_h = val;
			srrd_pkg::REG_RAW_MODE: raw_on = val[0];
			default: ;
		endcase
	endtask

	task automatic set_frame(input logic [7:0] w, input logic [7:0] h, input logic raw);
		write_reg(srrd_pkg::REG_FRAME_WIDTH, w);
		write_reg(srrd_pkg::REG_FRAME_HEIGHT, h);
		write_reg(srrd_pkg::REG_RAW_MODE, {7'd0, raw});
		settings_cnt++;
	endtask

	// pause until every transaction is in and every pixel out, then let the block settle
	task automatic wait_idle();
		while (byte_q.size() != 0 || in_valid || pending_pixels.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// well-formed command streams with random content, plus some noise
	task automatic queue_coded(input int n_bytes, input bit open_frame);
		int stop_at;
		int cnt;
		int skip_len;
		int sel;
		bit start_next;
		stop_at = byte_q.size() + n_bytes;
		start_next = open_frame;
		while (byte_q.size() < stop_at) begin
			cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
			skip_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
				: $urandom_range(0, 6);
			sel = $urandom_range(0, 9);
			if (sel < 3) begin
				push_byte(srrd_pkg::CMD_SKIP_BIT | 8'(skip_len), start_next);
			end else if (sel < 6) begin
				push_byte(srrd_pkg::CMD_REPEAT_BIT | 8'(cnt), start_next);
				push_byte(8'($urandom), $urandom_range(0, 29) == 0);
			end else if (sel < 9) begin
				push_byte(8'(cnt), start_next);
				repeat (cnt) push_byte(8'($urandom), 1'b0);
			end else begin
				push_byte(8'($urandom), start_next);
			end
			start_next = ($urandom_range(0, 59) == 0);
		end
	endtask

	task automatic queue_raw(input int n_bytes, input bit open_frame);
		bit start_next;
		start_next = open_frame;
		repeat (n_bytes) begin
			push_byte(8'($urandom), start_next);
			start_next = ($urandom_range(0, 39) == 0);
		end
	endtask

	// driver: bursts of transactions separated by random gaps
	int burst_left = 5;
	int gap_left = 0;

	always @(posedge clk) begin : driver
		byte_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_pixels(data_byte, frame_start);
				bytes_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (byte_q.size() != 0
						&& !(byte_q[0].drain && pending_pixels.size() != 0)) begin
					nxt = byte_q.pop_front();
					data_byte <= nxt.data;
					frame_start <= nxt.start;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks pixels and stalls the result side in changing modes
	int stall_left = 0;
	int stall_mode = 0;
	int stall_tick = 0;

	always @(posedge clk) begin : monitor
		pixel_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%0d",
						pixel_x, pixel_y, color_index));
				end else begin
					want = pending_pixels.pop_front();
					if (pixel_x !== want.x)
						report_mismatch($sformatf("pixel_x got %0d want %0d", pixel_x, want.x));
					if (pixel_y !== want.y)
						report_mismatch($sformatf("pixel_y got %0d want %0d", pixel_y, want.y));
					if (color_index !== want.color)
						report_mismatch($sformatf("color_index got %0d want %0d",
							color_index, want.color));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run got %0b want %0b",
							last_of_run, want.last));
					pixels_checked++;
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(50, 300);
			end
			stall_left--;
			stall_tick++;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ((stall_tick % 5) < 2);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("sprite_row_rle_decoder: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// coded frame, 8 wide, 3 rows
		set_frame(8'd8, 8'd3, 1'b0);
		push_byte(8'h80, 1'b1);  // skip of zero
		push_byte(8'h02, 1'b0);  // two literals at the color extremes
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h43, 1'b0);  // repeat of three
		push_byte(8'hAA, 1'b0);
		push_byte(8'h40, 1'b0);  // repeat count of zero still eats the color
		push_byte(8'h55, 1'b0);
		push_byte(8'h00, 1'b0);  // literal count of zero
		push_byte(8'h7F, 1'b0);  // longest repeat, runs past the width
		push_byte(8'h12, 1'b0);
		byte_q[byte_q.size() - 1].drain = 1'b1;
		push_byte(8'hFF, 1'b0);  // skip far past the width
		push_byte(8'h88, 1'b0);  // skip exactly to the width, frame done
		push_byte(8'h03, 1'b1);  // new frame, literal broken by another frame start
		push_byte(8'h11, 1'b0);
		push_byte(8'h22, 1'b0);
		push_byte(8'h44, 1'b1);
		push_byte(8'h77, 1'b0);
		wait_idle();

		set_frame(8'd0, 8'd3, 1'b0);  // zero width
		push_byte(8'h41, 1'b1);
		wait_idle();
		set_frame(8'd5, 8'd0, 1'b0);  // zero height
		push_byte(8'h00, 1'b1);
		wait_idle();

		// raw frame, 3 wide, 2 rows, then bytes past the end
		set_frame(8'd3, 8'd2, 1'b1);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h33, 1'b0);
		wait_idle();

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: set_frame(8'd255, 8'd255, 1'b0);
				1: set_frame(8'd1, 8'd255, 1'b1);
				2: set_frame(8'd255, 8'd1, 1'b1);
				3: set_frame(8'd0, 8'd200, 1'b0);
				default: set_frame(8'($urandom_range(1, 40)), 8'($urandom_range(1, 10)),
					$urandom_range(0, 3) == 0);
			endcase
			if (raw_on)
				queue_raw(60, $urandom_range(0, 3) != 0);
			else
				queue_coded((p == 3) ? 12 : 60, $urandom_range(0, 3) != 0);
			wait_idle();
		end

		if (pending_pixels.size() != 0)
			report_mismatch($sformatf("%0d pixels never came out", pending_pixels.size()));
		$display("sent %0d bytes under %0d frame settings (coded, raw, zero and full sizes)",
			bytes_sent, settings_cnt);
		$display("checked %0d pixels, %0d errors", pixels_checked, errors);
		if (errors == 0)
			$display("sprite_row_rle_decoder: match");
		else
			$display("sprite_row_rle_decoder: mismatch");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/srrd_pkg.sv
src/srrd_ctrl.sv
src/srrd_datapath.sv
src/sprite_row_rle_decoder.sv
src/srrd_checker.sv
test/sprite_row_rle_decoder_tb.sv
